@@ hdl/aps_pkg.sv @@
// ----------------------------------------------------------------------------
// aps_pkg
// Shared widths, register indexes, reset values and the command and status
// structs that join the controller and the datapath of the partial synth.
// ----------------------------------------------------------------------------
package aps_pkg;

   localparam int unsigned MAX_PARTIALS_DEF    = 64;
   localparam int unsigned SINE_TABLE_SIZE_DEF = 1024;

   localparam int unsigned F0_W     = 24;
   localparam int unsigned AMP_W    = 16;
   localparam int unsigned SAMPLE_W = 24;
   localparam int unsigned INH_W    = 16;
   localparam int unsigned SCALE_W  = 20;
   localparam int unsigned PHASE_W  = 32;
   localparam int unsigned SINE_W   = 16;

   // amplitude * sine is Q.30, the contribution Q.15
   localparam int unsigned FRAC_SHIFT = 15;

   // phase step is bits [56:25] of fsum * scale
   localparam int unsigned FSUM_W     = 57;
   localparam int unsigned FSUM_SPLIT = 29;

   localparam logic [16:0] ONE_Q16 = 17'h10000;

   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 20;

   localparam logic [CSR_INDEX_W-1:0] CSR_HARMONIC_ENABLE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INHARMONICITY    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP_SCALE = 2'd2;

   localparam logic               ENABLE_RESET = 1'b1;
   localparam logic [INH_W-1:0]   INH_RESET    = 16'd0;
   localparam logic [SCALE_W-1:0] SCALE_RESET  = 20'd89478;

   typedef struct packed {
      logic accept;
      logic stage_a;
      logic stage_b;
      logic stage_c;
      logic stage_d;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic out_free;
   } sts_type;

endpackage

@@ hdl/aps_sine_rom.sv @@
// ----------------------------------------------------------------------------
// aps_sine_rom
// Full-wave sine table, round(32767 * sin(2*pi*i/N)), built at elaboration
// from a quarter-wave Taylor series, with a registered read port.
// ----------------------------------------------------------------------------
module aps_sine_rom #(
   parameter int unsigned SINE_TABLE_SIZE = aps_pkg::SINE_TABLE_SIZE_DEF
) (
   input  logic                                 clock,
   input  logic                                 rd_en,
   input  logic [$clog2(SINE_TABLE_SIZE)-1:0]   rd_addr,
   output logic signed [aps_pkg::SINE_W-1:0]    rd_data
);

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // term * x^2 in Q30
   function automatic longint unsigned sq_step(longint unsigned term,
                                               longint unsigned x);
      longint unsigned t;
      begin
         t = (term * x) >> 30;
         t = (t * x) >> 30;
         return t;
      end
   endfunction

   function automatic logic signed [aps_pkg::SINE_W-1:0] sine_entry(int unsigned i);
      longint unsigned q;
      longint unsigned r;
      longint unsigned x;
      longint unsigned term;
      longint signed   acc;
      longint signed   v;
      begin
         q = (4 * longint'(i)) / SINE_TABLE_SIZE;
         r = 4 * longint'(i) - q * SINE_TABLE_SIZE;
         if (q[0]) begin
            r = SINE_TABLE_SIZE - r;
         end
         x    = (r * HALF_PI_Q30) / SINE_TABLE_SIZE;
         term = x;
         acc  = longint'(x);
         term = sq_step(term, x) / 64'd6;
         acc  = acc - longint'(term);
         term = sq_step(term, x) / 64'd20;
         acc  = acc + longint'(term);
         term = sq_step(term, x) / 64'd42;
         acc  = acc - longint'(term);
         term = sq_step(term, x) / 64'd72;
         acc  = acc + longint'(term);
         term = sq_step(term, x) / 64'd110;
         acc  = acc - longint'(term);
         term = sq_step(term, x) / 64'd156;
         acc  = acc + longint'(term);
         if (acc < 0) begin
            acc = 0;
         end
         v = (acc * 32767 + (64'sd1 << 29)) >>> 30;
         if (v > 32767) begin
            v = 32767;
         end
         if (q[1]) begin
            v = -v;
         end
         return v[aps_pkg::SINE_W-1:0];
      end
   endfunction

   logic signed [aps_pkg::SINE_W-1:0] rom_table [SINE_TABLE_SIZE];
   logic signed [aps_pkg::SINE_W-1:0] rd_data_ff;

   for (genvar gi = 0; gi < SINE_TABLE_SIZE; gi++) begin : g_entry
      localparam logic signed [aps_pkg::SINE_W-1:0] ENTRY = sine_entry(gi);
      assign rom_table[gi] = ENTRY;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rom_table[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/aps_ctrl.sv @@
// ----------------------------------------------------------------------------
// aps_ctrl
// Sequencer for one partial: accept, four arithmetic steps, then commit of
// phase, counter and sum. Commit of a last partial waits for a free result
// register.
// ----------------------------------------------------------------------------
module aps_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  aps_pkg::sts_type sts,
   output aps_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_PROD,
      ST_SUM,
      ST_STEP,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   logic      stall_ff;

   always_comb begin
      cmd         = '0;
      cmd.accept  = (state_ff == ST_IDLE) && req_valid;
      cmd.stage_a = (state_ff == ST_MULT);
      cmd.stage_b = (state_ff == ST_PROD);
      cmd.stage_c = (state_ff == ST_SUM);
      cmd.stage_d = (state_ff == ST_STEP);
      cmd.commit  = (state_ff == ST_COMMIT) && (!sts.last || sts.out_free);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_MULT;
                  stall_ff <= 1'b1;
               end
            end
            ST_MULT: begin
               state_ff <= ST_PROD;
            end
            ST_PROD: begin
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               state_ff <= ST_STEP;
            end
            ST_STEP: begin
               state_ff <= ST_COMMIT;
            end
            ST_COMMIT: begin
               if (!sts.last || sts.out_free) begin
                  state_ff <= ST_IDLE;
                  stall_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               stall_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_stall = stall_ff;

endmodule

@@ hdl/aps_datapath.sv @@
// ----------------------------------------------------------------------------
// aps_datapath
// Configuration registers, partial counter, phase store, sine lookup,
// partial frequency and phase step multipliers, saturating sum and the
// result register.
// ----------------------------------------------------------------------------
module aps_datapath #(
   parameter int unsigned MAX_PARTIALS    = aps_pkg::MAX_PARTIALS_DEF,
   parameter int unsigned SINE_TABLE_SIZE = aps_pkg::SINE_TABLE_SIZE_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  aps_pkg::cmd_type                       cmd,
   output aps_pkg::sts_type                       sts,
   input  logic                                   csr_valid,
   input  logic [aps_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [aps_pkg::CSR_DATA_W-1:0]         csr_wdata,
   input  logic [aps_pkg::F0_W-1:0]               req_f0_now,
   input  logic [aps_pkg::F0_W-1:0]               req_f0_next,
   input  logic signed [aps_pkg::AMP_W-1:0]       req_amplitude,
   input  logic                                   req_last_partial,
   input  logic                                   rsp_stall,
   output logic                                   rsp_valid,
   output logic signed [aps_pkg::SAMPLE_W-1:0]    rsp_sample_value
);

   localparam int unsigned KW    = $clog2(MAX_PARTIALS + 2);
   localparam int unsigned AW    = (MAX_PARTIALS > 1) ? $clog2(MAX_PARTIALS) : 1;
   localparam int unsigned IW    = $clog2(SINE_TABLE_SIZE);
   localparam int unsigned NW    = $clog2(SINE_TABLE_SIZE + 1);
   localparam int unsigned IPW   = aps_pkg::PHASE_W + NW;
   localparam int unsigned T1W   = aps_pkg::INH_W + KW;
   localparam int unsigned MAW   = T1W + 1;
   localparam int unsigned MW    = KW + MAW;
   localparam int unsigned MLW   = (MW + 1) / 2;
   localparam int unsigned MHW   = MW - MLW;
   localparam int unsigned FSW   = aps_pkg::F0_W + 1;
   localparam int unsigned FLW   = FSW + MLW;
   localparam int unsigned FHW   = FSW + MHW;
   localparam int unsigned PLW   = aps_pkg::FSUM_SPLIT + aps_pkg::SCALE_W;
   localparam int unsigned PHW   = aps_pkg::FSUM_W - aps_pkg::FSUM_SPLIT;
   localparam int unsigned PFW   = PHW + aps_pkg::SCALE_W;
   localparam int unsigned PRODW = aps_pkg::AMP_W + aps_pkg::SINE_W;
   localparam int unsigned CW    = PRODW - aps_pkg::FRAC_SHIFT;
   localparam int unsigned SW    = aps_pkg::SAMPLE_W;

   localparam logic signed [PRODW-1:0] ROUND_HALF = PRODW'(1) << (aps_pkg::FRAC_SHIFT - 1);
   localparam logic signed [SW-1:0]    SUM_MAX    = {1'b0, {(SW - 1){1'b1}}};
   localparam logic signed [SW-1:0]    SUM_MIN    = {1'b1, {(SW - 1){1'b0}}};

   // configuration
   logic                          enable_ff;
   logic [aps_pkg::INH_W-1:0]     inh_ff;
   logic [aps_pkg::SCALE_W-1:0]   scale_ff;

   // sequence state
   logic [KW-1:0]                 k_ff;
   logic [KW-1:0]                 k_in;
   logic signed [SW-1:0]          sum_ff;
   logic signed [SW-1:0]          sum_in;

   // phase store
   logic [aps_pkg::PHASE_W-1:0]   phase_mem_ff [MAX_PARTIALS];
   logic [MAX_PARTIALS-1:0]       phase_vld_ff;
   logic [aps_pkg::PHASE_W-1:0]   phase_rd_ff;
   logic                          vld_rd_ff;

   // item registers
   logic [FSW-1:0]                fs_ff;
   logic signed [aps_pkg::AMP_W-1:0] amp_ff;
   logic                          last_ff;
   logic                          active_ff;
   logic [T1W-1:0]                t1_ff;
   logic [MW-1:0]                 m_ff;
   logic [aps_pkg::PHASE_W-1:0]   phase_ff;
   logic [IW-1:0]                 idx_ff;
   logic [FLW-1:0]                flo_ff;
   logic [FHW-1:0]                fhi_ff;
   logic [aps_pkg::FSUM_W-1:0]    fsum_ff;
   logic signed [PRODW-1:0]       prod_ff;
   logic [PLW-1:0]                plo_ff;
   logic [PHW-1:0]                phi_ff;

   // result register
   logic                          rsp_valid_ff;
   logic signed [SW-1:0]          rsp_value_ff;

   logic [KW-1:0]                 k_dec;
   logic [AW-1:0]                 addr;
   logic [aps_pkg::PHASE_W-1:0]   phase_cur;
   logic [IPW-1:0]                idx_prod;
   logic signed [aps_pkg::SINE_W-1:0] sine_q;
   logic [PFW-1:0]                phi_full;
   logic [aps_pkg::FSUM_W-1:0]    step_full;
   logic [aps_pkg::PHASE_W-1:0]   step_in;
   logic signed [PRODW-1:0]       rnd;
   logic signed [CW-1:0]          contrib;
   logic signed [SW:0]            sum_wide;
   logic                          out_free;

   aps_sine_rom #(
      .SINE_TABLE_SIZE(SINE_TABLE_SIZE)
   ) u_sine_rom (
      .clock   (clock),
      .rd_en   (cmd.stage_b),
      .rd_addr (idx_ff),
      .rd_data (sine_q)
   );

   assign k_dec     = k_ff - KW'(1);
   assign addr      = k_dec[AW-1:0];
   assign phase_cur = vld_rd_ff ? phase_rd_ff : '0;
   assign idx_prod  = IPW'(phase_cur) * IPW'(SINE_TABLE_SIZE);
   assign phi_full  = PFW'(fsum_ff[aps_pkg::FSUM_W-1:aps_pkg::FSUM_SPLIT]) * PFW'(scale_ff);
   assign step_full = aps_pkg::FSUM_W'(plo_ff)
                    + (aps_pkg::FSUM_W'(phi_ff) << aps_pkg::FSUM_SPLIT);
   assign step_in   = step_full[aps_pkg::FSUM_W-1 -: aps_pkg::PHASE_W];
   assign rnd       = prod_ff + ROUND_HALF;
   assign contrib   = rnd[PRODW-1:aps_pkg::FRAC_SHIFT];
   assign sum_wide  = (SW + 1)'(sum_ff) + (SW + 1)'(contrib);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (sum_wide[SW] != sum_wide[SW-1]) begin
         sum_in = sum_wide[SW] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_in = sum_wide[SW-1:0];
      end
   end

   always_comb begin
      if (last_ff) begin
         k_in = KW'(1);
      end else if (k_ff <= KW'(MAX_PARTIALS)) begin
         k_in = k_ff + KW'(1);
      end else begin
         k_in = k_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= aps_pkg::ENABLE_RESET;
         inh_ff       <= aps_pkg::INH_RESET;
         scale_ff     <= aps_pkg::SCALE_RESET;
         k_ff         <= KW'(1);
         sum_ff       <= '0;
         phase_vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               aps_pkg::CSR_HARMONIC_ENABLE: begin
                  enable_ff <= csr_wdata[0];
               end
               aps_pkg::CSR_INHARMONICITY: begin
                  inh_ff <= csr_wdata[aps_pkg::INH_W-1:0];
               end
               aps_pkg::CSR_PHASE_STEP_SCALE: begin
                  scale_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (cmd.stage_d && active_ff) begin
            sum_ff <= sum_in;
         end
         if (cmd.commit) begin
            k_ff <= k_in;
            if (active_ff) begin
               phase_vld_ff[addr] <= 1'b1;
            end
            if (last_ff) begin
               sum_ff <= '0;
            end
         end
         if (cmd.commit && last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // phase store, read on accept and written on commit
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         phase_rd_ff <= phase_mem_ff[addr];
         vld_rd_ff   <= phase_vld_ff[addr];
      end
      if (cmd.commit && active_ff) begin
         phase_mem_ff[addr] <= phase_ff + step_in;
      end
   end

   // arithmetic steps
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         fs_ff     <= FSW'(req_f0_now) + FSW'(req_f0_next);
         amp_ff    <= req_amplitude;
         last_ff   <= req_last_partial;
         active_ff <= enable_ff && (k_ff <= KW'(MAX_PARTIALS));
         t1_ff     <= T1W'(inh_ff) * T1W'(k_dec);
      end
      if (cmd.stage_a) begin
         phase_ff <= phase_cur;
         idx_ff   <= idx_prod[aps_pkg::PHASE_W +: IW];
         m_ff     <= MW'(k_ff) * MW'(MAW'(aps_pkg::ONE_Q16) + MAW'(t1_ff));
      end
      if (cmd.stage_b) begin
         flo_ff <= FLW'(fs_ff) * FLW'(m_ff[MLW-1:0]);
         fhi_ff <= FHW'(fs_ff) * FHW'(m_ff[MW-1:MLW]);
      end
      if (cmd.stage_c) begin
         fsum_ff <= aps_pkg::FSUM_W'(flo_ff) + (aps_pkg::FSUM_W'(fhi_ff) << MLW);
         prod_ff <= PRODW'(amp_ff) * PRODW'(sine_q);
      end
      if (cmd.stage_d) begin
         plo_ff <= PLW'(fsum_ff[aps_pkg::FSUM_SPLIT-1:0]) * PLW'(scale_ff);
         phi_ff <= phi_full[PHW-1:0];
      end
      if (cmd.commit && last_ff) begin
         rsp_value_ff <= enable_ff ? sum_ff : '0;
      end
   end

   assign sts.last     = last_ff;
   assign sts.out_free = out_free;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_value = rsp_value_ff;

endmodule

@@ hdl/additive_partial_synth.sv @@
// ----------------------------------------------------------------------------
// additive_partial_synth
// Additive synthesis oscillator bank: one partial per input transfer, one
// saturated sample per last partial.
// ----------------------------------------------------------------------------
// Input channel req_*: one partial of the current sample per transfer, with
// the fundamental now and at the next sample, its amplitude and a last flag.
// Partials are numbered from one; partials beyond MAX_PARTIALS are ignored.
// Result channel rsp_*: one sample value per last partial.
// Configuration channel csr_*: always ready; the user must write it only
// between partials, which the block does not enforce. Each partial passes
// the accept, four registered multiply and add steps for frequency, phase
// step and sine product, then the commit that writes the phase store. The
// next partial is taken the cycle after commit. A sample appears on
// rsp_valid the cycle after its last partial commits.
// Reset sets the counter to one, clears the sum, the result valid flag and
// the phase valid flags (all phases read as zero) and loads the register
// defaults; no clearing pass is needed.
// A stalled result is held in the output register while further partials are
// taken; only the commit of the next last partial waits for it to leave.
// ----------------------------------------------------------------------------
module additive_partial_synth #(
   parameter int unsigned MAX_PARTIALS    = aps_pkg::MAX_PARTIALS_DEF,
   parameter int unsigned SINE_TABLE_SIZE = aps_pkg::SINE_TABLE_SIZE_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [aps_pkg::F0_W-1:0]               req_f0_now,
   input  logic [aps_pkg::F0_W-1:0]               req_f0_next,
   input  logic signed [aps_pkg::AMP_W-1:0]       req_amplitude,
   input  logic                                   req_last_partial,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [aps_pkg::SAMPLE_W-1:0]    rsp_sample_value,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [aps_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [aps_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   aps_pkg::cmd_type cmd;
   aps_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   aps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   aps_datapath #(
      .MAX_PARTIALS    (MAX_PARTIALS),
      .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_valid        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_f0_now       (req_f0_now),
      .req_f0_next      (req_f0_next),
      .req_amplitude    (req_amplitude),
      .req_last_partial (req_last_partial),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_sample_value (rsp_sample_value)
   );

   // one partial in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second partial taken while one is in flight");

   // a sample only comes from the commit of a last partial
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.commit && sts.last))
      else $error("result raised without a last partial commit");

   // a held sample is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && sts.last) |-> (!rsp_valid || !rsp_stall))
      else $error("result register overwritten while stalled");

endmodule

@@ tb/additive_partial_synth_tb.sv @@
// ----------------------------------------------------------------------------
// additive_partial_synth_tb
// Self-checking bench for the additive synthesis oscillator bank. A driver
// takes partials from a queue and offers them on req_*, and a predictor
// computes the expected samples from its own phase store and register copy.
// A monitor compares each sample taken from rsp_* with the oldest expected
// one. The run steps through register settings written between phases,
// random idling on both sides, a long hold-off on the result side and the
// cases of partials beyond the store, disabled synthesis and a zero phase step.
// ----------------------------------------------------------------------------
module additive_partial_synth_tb;

   localparam int unsigned NUM_PARTIALS = aps_pkg::MAX_PARTIALS_DEF;
   localparam int unsigned SINE_SIZE    = aps_pkg::SINE_TABLE_SIZE_DEF;
   localparam longint      HALF_PI_Q30  = 64'd1686629713;
   localparam longint      SUM_HI       = 64'sd8388607;
   localparam longint      SUM_LO       = -64'sd8388608;
   localparam int          SETTLE       = 20;
   localparam int          HOLD_CYCLES  = 400;
   localparam int          CYCLE_LIMIT  = 400000;

   // index past the last register, ignored by the block
   localparam logic [aps_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   typedef struct packed {
      logic [aps_pkg::F0_W-1:0]         f0_now;
      logic [aps_pkg::F0_W-1:0]         f0_next;
      logic signed [aps_pkg::AMP_W-1:0] amplitude;
      logic                             last_partial;
   } partial_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [aps_pkg::F0_W-1:0]            req_f0_now = '0;
   logic [aps_pkg::F0_W-1:0]            req_f0_next = '0;
   logic signed [aps_pkg::AMP_W-1:0]    req_amplitude = '0;
   logic                                req_last_partial = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic signed [aps_pkg::SAMPLE_W-1:0] rsp_sample_value;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [aps_pkg::CSR_INDEX_W-1:0]     csr_index = '0;
   logic [aps_pkg::CSR_DATA_W-1:0]      csr_wdata = '0;

   additive_partial_synth dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_f0_now       (req_f0_now),
      .req_f0_next      (req_f0_next),
      .req_amplitude    (req_amplitude),
      .req_last_partial (req_last_partial),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_value (rsp_sample_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state and register copy
   int                          sine_lut [SINE_SIZE];
   logic [aps_pkg::PHASE_W-1:0] phase_store [NUM_PARTIALS];
   int unsigned                 part_idx;
   longint                      sum_acc;
   logic                        cfg_enable;
   logic [aps_pkg::INH_W-1:0]   cfg_inh;
   logic [aps_pkg::SCALE_W-1:0] cfg_scale;

   partial_type                         partial_q [$];
   logic signed [aps_pkg::SAMPLE_W-1:0] sample_expect_q [$];
   int                                  n_queued = 0;
   int                                  n_accepted = 0;
   int                                  n_fail = 0;
   int                                  sender_idle_pct = 27;
   int                                  recv_idle_pct = 61;
   int                                  hold_req = 0;
   int                                  hold_seen = 0;
   int                                  hold_left = 0;
   int                                  cycle_count = 0;

   // sine over the first quarter, Q30 in and out
   function automatic longint quarter_sine(input longint unsigned x);
      longint unsigned term;
      longint          acc;
      term = x;
      acc  = longint'(x);
      for (int unsigned j = 1; j <= 6; j++) begin
         term = (term * x) >> 30;
         term = (term * x) >> 30;
         term = term / ((2 * j) * (2 * j + 1));
         if (j % 2 == 1) acc = acc - longint'(term);
         else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      return acc;
   endfunction

   function automatic int sine_at(input longint unsigned i);
      longint unsigned q, r, x;
      longint          s, v;
      q = (4 * i) / SINE_SIZE;
      r = 4 * i - q * SINE_SIZE;
      if (q[0]) r = SINE_SIZE - r;
      x = (r * HALF_PI_Q30) / SINE_SIZE;
      s = quarter_sine(x);
      v = (s * 32767 + (64'sd1 << 29)) / (64'sd1 << 30);
      if (v > 32767) v = 32767;
      return q[1] ? -int'(v) : int'(v);
   endfunction

   // partial frequency in Q.24 Hz
   function automatic logic [63:0] partial_freq(input logic [aps_pkg::F0_W-1:0] f0,
                                                input longint unsigned k);
      logic [63:0] m;
      m = k * (64'd65536 + 64'(cfg_inh) * (k - 1));
      return 64'(f0) * m;
   endfunction

   task automatic synth_partial(input partial_type p);
      logic [aps_pkg::PHASE_W-1:0]         ph;
      logic [63:0]                         fsum, prod, tidx;
      longint                              contrib;
      logic signed [aps_pkg::SAMPLE_W-1:0] v;
      if (cfg_enable && part_idx >= 1 && part_idx <= NUM_PARTIALS) begin
         ph      = phase_store[part_idx-1];
         tidx    = (64'(ph) * SINE_SIZE) >> 32;
         contrib = (longint'(p.amplitude) * sine_lut[tidx] + 16384)
                   >>> aps_pkg::FRAC_SHIFT;
         fsum    = partial_freq(p.f0_now, part_idx) + partial_freq(p.f0_next, part_idx);
         prod    = fsum * 64'(cfg_scale);
         sum_acc = sum_acc + contrib;
         if (sum_acc > SUM_HI) sum_acc = SUM_HI;
         if (sum_acc < SUM_LO) sum_acc = SUM_LO;
         phase_store[part_idx-1] = ph + prod[56:25];
      end
      if (p.last_partial) begin
         v = cfg_enable ? aps_pkg::SAMPLE_W'(sum_acc) : '0;
         sample_expect_q.push_back(v);
         sum_acc  = 0;
         part_idx = 1;
      end else if (part_idx <= NUM_PARTIALS) begin
         part_idx++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      partial_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            synth_partial({req_f0_now, req_f0_next, req_amplitude, req_last_partial});
            n_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (partial_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               nxt = partial_q.pop_front();
               req_valid        <= 1'b1;
               req_f0_now       <= nxt.f0_now;
               req_f0_next      <= nxt.f0_next;
               req_amplitude    <= nxt.amplitude;
               req_last_partial <= nxt.last_partial;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and result-side stall
   always @(posedge clock) begin
      logic signed [aps_pkg::SAMPLE_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sample_expect_q.size() == 0) begin
            $error("sample_value: no sample expected, actual %0d", rsp_sample_value);
            n_fail++;
         end else begin
            want = sample_expect_q.pop_front();
            if (rsp_sample_value !== want) begin
               $error("sample_value: expected %0d, actual %0d", want, rsp_sample_value);
               n_fail++;
            end
         end
      end
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic push_partial(input logic [aps_pkg::F0_W-1:0] f0n,
                               input logic [aps_pkg::F0_W-1:0] f0x,
                               input logic signed [aps_pkg::AMP_W-1:0] amp,
                               input logic last);
      partial_q.push_back({f0n, f0x, amp, last});
      n_queued++;
   endtask

   function automatic int pick_partial_count();
      int r;
      r = $urandom_range(99);
      if (r < 85) return $urandom_range(1, 8);
      else if (r < 98) return $urandom_range(9, 64);
      return $urandom_range(65, 72);
   endfunction

   task automatic push_random_sample(input int n);
      logic [aps_pkg::F0_W-1:0]         base, f0n, f0x;
      logic signed [aps_pkg::AMP_W-1:0] amp;
      bit                               steady;
      steady = ($urandom_range(99) < 70);
      base   = aps_pkg::F0_W'($urandom_range(20 * 256, 4000 * 256));
      for (int i = 0; i < n; i++) begin
         if (steady) begin
            f0n = base;
            f0x = aps_pkg::F0_W'(32'(base) + $urandom_range(0, 2048) - 32'd1024);
         end else begin
            f0n = aps_pkg::F0_W'($urandom);
            f0x = aps_pkg::F0_W'($urandom);
         end
         case ($urandom_range(9))
            0: amp = 16'sh7FFF;
            1: amp = -16'sh8000;
            default: amp = aps_pkg::AMP_W'($urandom);
         endcase
         push_partial(f0n, f0x, amp, i == n - 1);
      end
   endtask

   task automatic run_random(input int target);
      int start;
      start = n_queued;
      while (n_queued - start < target) push_random_sample(pick_partial_count());
   endtask

   task automatic wait_idle();
      while (n_accepted != n_queued || sample_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // leaves csr_valid high; end_csr lowers it after the last write
   task automatic write_csr(input logic [aps_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [aps_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         aps_pkg::CSR_HARMONIC_ENABLE:  cfg_enable = data[0];
         aps_pkg::CSR_INHARMONICITY:    cfg_inh = data[aps_pkg::INH_W-1:0];
         aps_pkg::CSR_PHASE_STEP_SCALE: cfg_scale = data[aps_pkg::SCALE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic end_csr();
      csr_valid <= 1'b0;
   endtask

   initial begin
      for (int i = 0; i < SINE_SIZE; i++) sine_lut[i] = sine_at(i);
      for (int i = 0; i < NUM_PARTIALS; i++) phase_store[i] = '0;
      part_idx   = 1;
      sum_acc    = 0;
      cfg_enable = aps_pkg::ENABLE_RESET;
      cfg_inh    = aps_pkg::INH_RESET;
      cfg_scale  = aps_pkg::SCALE_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed partials with the reset register values
      push_partial(24'hFFFFFF, 24'hFFFFFF, 16'sh7FFF, 1'b1);
      push_partial(24'hFFFFFF, 24'hFFFFFF, -16'sh8000, 1'b1);
      push_partial(24'h000000, 24'h000000, 16'sh7FFF, 1'b1);
      push_partial(24'h000000, 24'h000000, -16'sh8000, 1'b1);
      push_partial(24'hFFFFFF, 24'h000000, -16'sh0001, 1'b1);
      for (int i = 0; i < 3; i++) push_partial(24'd25600, 24'd25600, 16'sh7FFF, 1'b0);
      push_partial(24'd25600, 24'd25700, -16'sh8000, 1'b1);
      push_partial(24'd12345, 24'd54321, 16'sh0001, 1'b0);
      push_partial(24'hFFFFFF, 24'hFFFFFF, 16'sh7FFF, 1'b0);
      push_partial(24'h000000, 24'hFFFFFF, -16'sh8000, 1'b1);
      for (int i = 0; i < 3; i++) begin
         push_partial(24'd112640, 24'd112640, 16'sh4000, 1'b0);
         push_partial(24'd112640, 24'd112900, -16'sh4000, 1'b1);
      end
      wait_idle();

      // extreme coefficient and step, with a long result hold-off
      write_csr(aps_pkg::CSR_HARMONIC_ENABLE, 20'd1);
      write_csr(aps_pkg::CSR_INHARMONICITY, 20'hFFFF);
      write_csr(aps_pkg::CSR_PHASE_STEP_SCALE, 20'hFFFFF);
      end_csr();
      hold_req++;
      run_random(250);
      push_random_sample(70);
      wait_idle();

      sender_idle_pct = 61;
      recv_idle_pct   = 27;
      write_csr(aps_pkg::CSR_INHARMONICITY, 20'd0);
      write_csr(aps_pkg::CSR_PHASE_STEP_SCALE, 20'd1);
      write_csr(CSR_UNUSED_INDEX, 20'($urandom));
      end_csr();
      run_random(250);
      wait_idle();

      // silent samples, partials beyond the store included
      write_csr(aps_pkg::CSR_HARMONIC_ENABLE, 20'd0);
      write_csr(aps_pkg::CSR_INHARMONICITY, 20'($urandom_range(0, 65535)));
      end_csr();
      run_random(120);
      push_random_sample(70);
      wait_idle();

      sender_idle_pct = 0;
      recv_idle_pct   = 0;
      write_csr(aps_pkg::CSR_HARMONIC_ENABLE, 20'd1);
      write_csr(aps_pkg::CSR_PHASE_STEP_SCALE, 20'd0);
      end_csr();
      run_random(120);
      wait_idle();

      write_csr(aps_pkg::CSR_PHASE_STEP_SCALE, 20'd89478);
      write_csr(aps_pkg::CSR_INHARMONICITY, 20'($urandom_range(0, 2000)));
      end_csr();
      hold_req++;
      run_random(250);
      push_random_sample(66);
      wait_idle();

      if (n_fail == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
